// File: rtl/spq_pkg.sv
// Shared types and constants for the strict-priority event queues.
package spq_pkg;

  // Command carried in an input beat.
  typedef enum logic {
    CMD_POST = 1'b0,
    CMD_TAKE = 1'b1
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_BAD_PRIORITY = 2'd2,
    ST_EMPTY        = 2'd3
  } status_t;

  // Classified command kinds handed from the front end to the back end.
  typedef enum logic [1:0] {
    KIND_POST   = 2'd0,
    KIND_TAKE   = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

  localparam int PRI_W = 3;
  localparam int REC_W = 32;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  process_id;
    logic [7:0]  event_code;
    logic [15:0] event_data;
    logic [2:0]  priority_req;
  } spq_in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_process_id;
    logic [7:0]  out_event_code;
    logic [15:0] out_event_data;
    logic [2:0]  out_priority;
  } spq_out_t;

  // Record layout: process id in 31..24, event code in 23..16, data in 15..0.
  typedef struct packed {
    kind_t            kind;
    logic [PRI_W-1:0] level;
    logic [REC_W-1:0] record;
  } spq_cmd_t;

endpackage

// File: rtl/spq_front.sv
// Front end: accepts input beats and classifies them into queue commands.
module spq_front #(
  parameter int NUM_LEVELS = 4
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  input  logic              fifo_full,
  output logic              push,
  output spq_pkg::spq_cmd_t push_data
);
  import spq_pkg::*;

  logic bad_level;

  assign in_stall  = fifo_full;
  assign push      = in_valid && !fifo_full;
  assign bad_level = {1'b0, in_data.priority_req} >= (PRI_W + 1)'(NUM_LEVELS);

  always_comb begin
    push_data.level  = in_data.priority_req;
    push_data.record = {in_data.process_id, in_data.event_code, in_data.event_data};
    case (in_data.command)
      CMD_POST: push_data.kind = bad_level ? KIND_REJECT : KIND_POST;
      CMD_TAKE: push_data.kind = KIND_TAKE;
      default:  push_data.kind = KIND_REJECT;
    endcase
  end

endmodule

// File: rtl/spq_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module spq_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spq_pkg::spq_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output spq_pkg::spq_cmd_t pop_data
);
  import spq_pkg::*;

  spq_cmd_t   entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/spq_back.sv
// Back end: per-level ring pointers, the event slot memory and the result register.
module spq_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LEVELS  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  spq_pkg::spq_cmd_t cmd_data,
  output logic              cmd_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
  localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = FILL_W + 1;
  localparam int MEM_DEPTH = NUM_LEVELS << SLOT_W;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic [FILL_W-1:0] fill_r [NUM_LEVELS];
  logic [FILL_W-1:0] fill_nxt [NUM_LEVELS];
  logic [SLOT_W-1:0] head_r [NUM_LEVELS];
  logic [SLOT_W-1:0] head_nxt [NUM_LEVELS];
  back_state_t       state_r, state_nxt;
  logic [LVL_W-1:0]  take_lvl_r, take_lvl_nxt;
  logic              out_valid_r, out_valid_nxt;
  spq_out_t          out_data_r, out_data_nxt;

  logic [REC_W-1:0]  slots_mem [MEM_DEPTH];
  logic [REC_W-1:0]  rd_data_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;

  logic              out_free;
  logic [LVL_W-1:0]  cmd_lvl, enc_lvl;
  logic              any_busy;
  logic [SUM_W-1:0]  post_sum;
  logic [SLOT_W-1:0] post_slot, take_head, take_next;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign cmd_lvl   = cmd_data.level[LVL_W-1:0];

  // Highest-priority non-empty level.
  always_comb begin
    any_busy = 1'b0;
    enc_lvl  = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (fill_r[i] != '0) begin
        any_busy = 1'b1;
        enc_lvl  = LVL_W'(i);
      end
    end
  end

  always_comb begin
    post_sum  = SUM_W'(head_r[cmd_lvl]) + SUM_W'(fill_r[cmd_lvl]);
    post_slot = (post_sum >= SUM_W'(QUEUE_DEPTH)) ?
                SLOT_W'(post_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(post_sum);
    take_head = head_r[enc_lvl];
    take_next = (take_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : take_head + 1'b1;
  end

  always_comb begin
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    state_nxt     = state_r;
    take_lvl_nxt  = take_lvl_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = ADDR_W'({cmd_lvl, post_slot});

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop      = 1'b1;
          out_data_nxt = '0;
          case (cmd_data.kind)
            KIND_POST: begin
              out_valid_nxt = 1'b1;
              if (fill_r[cmd_lvl] == FILL_W'(QUEUE_DEPTH)) begin
                out_data_nxt.status = ST_FULL;
              end else begin
                mem_we            = 1'b1;
                fill_nxt[cmd_lvl] = fill_r[cmd_lvl] + 1'b1;
                out_data_nxt.status = ST_OK;
              end
            end
            KIND_TAKE: begin
              if (any_busy) begin
                mem_re            = 1'b1;
                mem_addr          = ADDR_W'({enc_lvl, take_head});
                fill_nxt[enc_lvl] = fill_r[enc_lvl] - 1'b1;
                head_nxt[enc_lvl] = take_next;
                take_lvl_nxt      = enc_lvl;
                state_nxt         = BK_READ;
              end else begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = ST_EMPTY;
              end
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = ST_BAD_PRIORITY;
            end
          endcase
        end
      end
      BK_READ: begin
        // The result register was emptied when the read was issued.
        out_valid_nxt               = 1'b1;
        out_data_nxt.status         = ST_OK;
        out_data_nxt.out_process_id = rd_data_r[31:24];
        out_data_nxt.out_event_code = rd_data_r[23:16];
        out_data_nxt.out_event_data = rd_data_r[15:0];
        out_data_nxt.out_priority   = PRI_W'(take_lvl_r);
        state_nxt                   = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    take_lvl_r <= take_lvl_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slots_mem[mem_addr] <= cmd_data.record;
    end
    if (mem_re) begin
      rd_data_r <= slots_mem[mem_addr];
    end
  end

`ifndef SYNTHESIS
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_fill_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r[g] <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill exceeds its depth");
  end

  a_read_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |-> !out_valid_r)
    else $error("result register busy while a slot read is pending");

  a_read_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_READ) |=> (out_valid_r && out_data_r.status == ST_OK))
    else $error("slot read did not produce a good result");

  a_reject_status: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd_data.kind == KIND_REJECT) |=>
      (out_valid_r && out_data_r.status == ST_BAD_PRIORITY))
    else $error("rejected post gave the wrong status");
`endif

endmodule

// File: rtl/strict_priority_event_queues_top.sv
// Top level of the strict-priority event queues: front end, command queue and back end.
// The block keeps NUM_LEVELS ring FIFOs of QUEUE_DEPTH event records each, level 0
// being the highest priority. Each input beat is either a post, which appends a
// record to the FIFO of the requested level, or a take, which pops the head record
// of the lowest-numbered non-empty level; every beat yields exactly one result beat.
// The front end classifies beats and pushes them into a two-entry command queue,
// so input is still accepted while a result waits at the output. The back end runs
// one command at a time: a post, a rejected post or a take with every level empty is
// handled in the idle state, while a take that finds a record also passes through the
// read state, because the event slot memory has a single port with a registered read.
// Posts can be sustained at one per cycle while the output is not stalled, but a take
// that finds a record makes the next command wait. A result beat passes through the
// command queue and the result register, and for a take that finds a record also
// through the slot read register. No clearing pass is run after reset: a slot is only
// read after a post has written it, so of the queue state only the per-level fill
// counts and head pointers are reset.
module strict_priority_event_queues_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LEVELS  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::spq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  // Beats travelling from the front end into the command queue.
  logic     push;
  spq_cmd_t push_data;
  logic     fifo_full;

  // Commands travelling from the command queue into the back end.
  logic     cmd_valid;
  logic     cmd_pop;
  spq_cmd_t cmd_data;

  // The front end checks the priority of a post against the number of levels.
  spq_front #(
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_full (fifo_full),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front end keep taking beats while the back end is busy.
  spq_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (cmd_pop),
    .pop_valid (cmd_valid),
    .pop_data  (cmd_data)
  );

  // The back end owns all queue state and the registered result beat.
  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_LEVELS  (NUM_LEVELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: bench/strict_priority_event_queues_top_tb.sv
// Self-checking testbench for the strict-priority event queues top level.
`timescale 1ns / 100ps

module strict_priority_event_queues_top_tb;
  import spq_pkg::*;

  // The block is built with its default sizes, and the predictor below uses the same ones.
  localparam int DEPTH     = 16;
  localparam int LEVELS    = 4;
  // This is how long the receiver holds off once, so that the command queue fills and the
  // input stalls.
  localparam int LONG_HOLD = 60;
  // These are cycles with no beat accepted on either channel. The longest legitimate
  // stretch is the long hold-off above.
  localparam int WATCHDOG  = 1000;
  // The results of the last beats are out within a few cycles once everything has drained.
  localparam int TAIL      = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  spq_in_t   in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  spq_out_t  out_data;

  // The sender sets this request, and the receiver honours it.
  bit        long_hold_req = 1'b0;
  // Random idling on both sides is enabled while this is set.
  bit        idle_on       = 1'b1;
  int        fail_count    = 0;
  int        quiet_cycles  = 0;

  // These are the results that are still owed by the block, oldest first.
  spq_out_t  pending_results[$];

  // This is the predictor's own copy of the queue state.
  logic [31:0] slot_mem [LEVELS][DEPTH];
  int unsigned lvl_fill [LEVELS];
  int unsigned lvl_head [LEVELS];

  // A row of the directed table. Where fixed is set, the expected result is typed in.
  typedef struct {
    spq_in_t  item;
    bit       fixed;
    spq_out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  strict_priority_event_queues_top #(
    .QUEUE_DEPTH (DEPTH),
    .NUM_LEVELS  (LEVELS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // This computes the one result that an accepted beat causes and updates the queue state.
  // A post lands at head plus fill of its level. A take pops the lowest-numbered level
  // that holds a record.
  function automatic spq_out_t predict_event(input spq_in_t it);
    spq_out_t    r;
    int unsigned p;
    int unsigned s;
    logic [31:0] rec;
    bit          found;
    r     = '0;
    found = 1'b0;
    p     = it.priority_req;
    if (it.command == CMD_POST) begin
      if (p >= LEVELS) begin
        r.status = ST_BAD_PRIORITY;
      end else if (lvl_fill[p] >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        s = (lvl_head[p] + lvl_fill[p]) % DEPTH;
        slot_mem[p][s] = {it.process_id, it.event_code, it.event_data};
        lvl_fill[p]++;
        r.status = ST_OK;
      end
    end else begin
      r.status = ST_EMPTY;
      for (int l = 0; l < LEVELS && !found; l++) begin
        if (lvl_fill[l] != 0) begin
          rec              = slot_mem[l][lvl_head[l]];
          lvl_fill[l]--;
          lvl_head[l]      = (lvl_head[l] + 1) % DEPTH;
          r.status         = ST_OK;
          r.out_process_id = rec[31:24];
          r.out_event_code = rec[23:16];
          r.out_event_data = rec[15:0];
          r.out_priority   = 3'(l);
          found            = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic spq_in_t mk_post(input logic [7:0] pid, input logic [7:0] code,
                                      input logic [15:0] data, input logic [2:0] pri);
    spq_in_t it;
    it.command      = CMD_POST;
    it.process_id   = pid;
    it.event_code   = code;
    it.event_data   = data;
    it.priority_req = pri;
    return it;
  endfunction

  function automatic spq_in_t mk_take(input logic [2:0] pri);
    spq_in_t it;
    it              = '0;
    it.command      = CMD_TAKE;
    it.priority_req = pri;
    return it;
  endfunction

  function automatic spq_out_t mk_res(input status_t st, input logic [7:0] pid,
                                      input logic [7:0] code, input logic [15:0] data,
                                      input logic [2:0] pri);
    spq_out_t r;
    r.status         = st;
    r.out_process_id = pid;
    r.out_event_code = code;
    r.out_event_data = data;
    r.out_priority   = pri;
    return r;
  endfunction

  // Random content. Posts mostly name a real level, and about one in ten names one that is
  // out of range. A take carries a random priority as well, which the block must ignore.
  function automatic spq_in_t random_event(input int post_pct);
    spq_in_t it;
    it.command      = ($urandom_range(0, 99) < post_pct) ? CMD_POST : CMD_TAKE;
    it.process_id   = 8'($urandom);
    it.event_code   = 8'($urandom);
    it.event_data   = 16'($urandom);
    it.priority_req = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(LEVELS, 7))
                                                  : 3'($urandom_range(0, LEVELS - 1));
    return it;
  endfunction

  // This offers one beat and holds it until it is accepted. The expectation is booked at
  // the accepting edge, and then an idle burst may follow.
  task automatic send_beat(input spq_in_t item, input bit fixed, input spq_out_t want);
    spq_out_t predicted;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_event(item);
    pending_results.push_back(fixed ? want : predicted);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic run_phase(input int count, input int post_pct);
    for (int k = 0; k < count; k++) begin
      send_beat(random_event(post_pct), 1'b0, '0);
    end
  endtask

  // The sender goes quiet until every owed result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // This is the result monitor. Each accepted result beat is compared field by field with
  // the oldest expectation.
  always @(posedge clk) begin
    spq_out_t exp_res;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no expectation waiting: %0h", out_data);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        check_field("status", 32'(exp_res.status), 32'(out_data.status));
        check_field("out_process_id", 32'(exp_res.out_process_id),
                    32'(out_data.out_process_id));
        check_field("out_event_code", 32'(exp_res.out_event_code),
                    32'(out_data.out_event_code));
        check_field("out_event_data", 32'(exp_res.out_event_data),
                    32'(out_data.out_event_data));
        check_field("out_priority", 32'(exp_res.out_priority), 32'(out_data.out_priority));
      end
    end
  end

  // The watchdog ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver stalls in short random bursts while idling is enabled. It holds off once
  // for a long stretch when the sender asks for it, and it counts that stretch here.
  initial begin : receiver
    int n;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // This is the stimulus: reset, the directed table, random phases, and then the final
  // verdict.
  initial begin : stimulus
    for (int l = 0; l < LEVELS; l++) begin
      lvl_fill[l] = 0;
      lvl_head[l] = 0;
    end

    // An empty take straight after reset, posts with out-of-range priorities, and records
    // with all-ones and all-zero content at the lowest and highest levels. These are
    // followed by the strict ordering of takes, an empty take again, and a take whose
    // priority field must be ignored.
    dir_rows.push_back('{mk_take(3'd0), 1'b1, mk_res(ST_EMPTY, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_post(8'hFF, 8'hFF, 16'hFFFF, 3'd4), 1'b1,
                         mk_res(ST_BAD_PRIORITY, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_post(8'h5A, 8'hA5, 16'h1234, 3'd7), 1'b1,
                         mk_res(ST_BAD_PRIORITY, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_post(8'hFF, 8'hFF, 16'hFFFF, 3'd3), 1'b1,
                         mk_res(ST_OK, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_post(8'h00, 8'h00, 16'h0000, 3'd0), 1'b1,
                         mk_res(ST_OK, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_take(3'd0), 1'b1, mk_res(ST_OK, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_take(3'd0), 1'b1,
                         mk_res(ST_OK, 8'hFF, 8'hFF, 16'hFFFF, 3'd3)});
    dir_rows.push_back('{mk_take(3'd0), 1'b1, mk_res(ST_EMPTY, 8'h0, 8'h0, 16'h0, 3'd0)});
    dir_rows.push_back('{mk_take(3'd7), 1'b1, mk_res(ST_EMPTY, 8'h0, 8'h0, 16'h0, 3'd0)});
    // Level 2 is filled to the brim, and then one more post must be refused as full.
    for (int k = 0; k < DEPTH; k++) begin
      dir_rows.push_back('{mk_post(8'($urandom), 8'($urandom), 16'($urandom), 3'd2),
                           1'b0, '0});
    end
    dir_rows.push_back('{mk_post(8'h11, 8'h22, 16'h3344, 3'd2), 1'b1,
                         mk_res(ST_FULL, 8'h0, 8'h0, 16'h0, 3'd0)});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
    end

    // This phase is mostly posts, so levels fill up and full refusals turn up again.
    run_phase(100, 75);

    // The receiver holds off for a long stretch while beats keep coming, so the block
    // backs up and stalls its input.
    long_hold_req = 1'b1;
    run_phase(60, 50);

    // The sender pauses until every result is back, and then draining dominates.
    wait_drained();
    run_phase(120, 30);
    run_phase(100, 55);

    // The last part runs with no idling on either side.
    idle_on = 1'b0;
    run_phase(70, 50);

    wait_drained();
    repeat (TAIL) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: strict_priority_event_queues_top.f
rtl/spq_pkg.sv
rtl/spq_front.sv
rtl/spq_cmd_fifo.sv
rtl/spq_back.sv
rtl/strict_priority_event_queues_top.sv
bench/strict_priority_event_queues_top_tb.sv
